>>> hdl/assert_macros.svh
// Assertion helpers used by rounding_ambiguity_check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> hdl/rac_pkg.sv
// ----------------------------------------------------------------------------
// rac_pkg
// Constants and types for the rounding ambiguity check.
// ----------------------------------------------------------------------------
`default_nettype none

package rac_pkg;

  typedef logic [63:0] dbl_t;
  typedef logic [31:0] word_t;
  typedef logic [1:0]  rmode_t;

  localparam rmode_t RM_NEAREST = 2'd0;
  localparam rmode_t RM_ZERO    = 2'd1;
  localparam rmode_t RM_UP      = 2'd2;
  localparam rmode_t RM_DOWN    = 2'd3;

  localparam word_t MAG_MASK    = 32'h7fff_ffff;
  localparam word_t EXP_MASK    = 32'h7ff0_0000;
  localparam word_t NEAR_BIAS   = 32'h0350_0000;
  localparam word_t HMAN_MASK   = 32'h000f_ffff;
  localparam word_t ONE_EXP     = 32'h0010_0000;
  localparam word_t PROBE_BIT   = 32'h0000_0100;
  localparam word_t NEAR_TRUNC  = 32'hffff_fff8;
  localparam word_t DIR_BIAS    = 32'h0340_0000;
  localparam word_t DIR_TRUNC   = 32'hffff_fffc;
  localparam word_t FAR_LIMIT   = 32'd19 << 20;

  localparam dbl_t SGN64  = 64'h8000_0000_0000_0000;
  localparam dbl_t QBIT64 = 64'h0008_0000_0000_0000;
  localparam dbl_t DNAN64 = 64'h7ff8_0000_0000_0000;
  localparam dbl_t INF64  = 64'h7ff0_0000_0000_0000;
  localparam dbl_t MAXF64 = 64'h7fef_ffff_ffff_ffff;

endpackage

`default_nettype wire

>>> hdl/rac_if.sv
// ----------------------------------------------------------------------------
// rac_if
// Valid/ready channels carrying request and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface rac_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] z_bits;
  logic [63:0] err_bits;
  logic [1:0]  round_mode;
  modport source (output valid, z_bits, err_bits, round_mode, input ready);
  modport sink   (input valid, z_bits, err_bits, round_mode, output ready);
endinterface

interface rac_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] z_out;
  logic        ambiguous;
  modport source (output valid, z_out, ambiguous, input ready);
  modport sink   (input valid, z_out, ambiguous, output ready);
endinterface

`default_nettype wire

>>> hdl/rac_dir_add.sv
// ----------------------------------------------------------------------------
// rac_dir_add
// Double-precision add rounded toward zero, plus or minus infinity.
// ----------------------------------------------------------------------------
`default_nettype none

module rac_dir_add import rac_pkg::*; (
  input  wire dbl_t   a,
  input  wire dbl_t   b,
  input  wire rmode_t mode,
  output dbl_t        sum
);

  function automatic logic [5:0] lead_zeros(input logic [55:0] v);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 56; i++) begin
      if (v[i]) n = 6'(55 - i);
    end
    return n;
  endfunction

  logic         nan_a, nan_b, inf_a, inf_b;
  logic         a_big, sub, sgn, away, inexact, lost, lostn;
  dbl_t         big, sml;
  logic [10:0]  eb, es, eb_e, es_e, dexp, lim;
  logic [5:0]   dc, lz, sh;
  logic [55:0]  big_ext, sml_ext, al, m;
  logic [127:0] wide;
  logic [56:0]  acc;
  logic [11:0]  exp_n;
  logic [10:0]  exp_f;
  logic [62:0]  trunc, rnd;
  logic         inc;

  always_comb begin
    nan_a = (a[62:52] == 11'h7ff) && (a[51:0] != '0);
    nan_b = (b[62:52] == 11'h7ff) && (b[51:0] != '0);
    inf_a = (a[62:0] == INF64[62:0]);
    inf_b = (b[62:0] == INF64[62:0]);

    // order by magnitude so the subtract never goes negative
    a_big = (a[62:0] >= b[62:0]);
    big   = a_big ? a : b;
    sml   = a_big ? b : a;
    sub   = a[63] ^ b[63];
    sgn   = big[63];
    away  = ((mode == RM_UP) && !sgn) || ((mode == RM_DOWN) && sgn);

    eb   = big[62:52];
    es   = sml[62:52];
    eb_e = (eb == '0) ? 11'd1 : eb;
    es_e = (es == '0) ? 11'd1 : es;
    dexp = eb_e - es_e;
    dc   = (dexp > 11'd63) ? 6'd63 : dexp[5:0];

    big_ext = {(eb != '0), big[51:0], 3'b000};
    sml_ext = {(es != '0), sml[51:0], 3'b000};
    wide    = {sml_ext, 72'd0} >> dc;
    al      = wide[127:72];
    lost    = |wide[71:0];

    // shifted-out bits count as one unit taken off, keeping the floor exact
    if (sub) acc = {1'b0, big_ext} - {1'b0, al} - {56'd0, lost};
    else     acc = {1'b0, big_ext} + {1'b0, al};

    lz  = lead_zeros(acc[55:0]);
    lim = eb_e - 11'd1;
    if (acc[56]) begin
      m     = acc[56:1];
      lostn = acc[0];
      exp_n = {1'b0, eb_e} + 12'd1;
      sh    = 6'd0;
    end else begin
      sh    = ({5'd0, lz} < lim) ? lz : lim[5:0];
      m     = acc[55:0] << sh;
      lostn = 1'b0;
      exp_n = {1'b0, eb_e} - {6'd0, sh};
    end
    exp_f   = m[55] ? exp_n[10:0] : 11'd0;
    inexact = lost | lostn | (|m[2:0]);
    trunc   = {exp_f, m[54:3]};
    inc     = inexact && away;
    rnd     = trunc + {62'd0, inc};

    if (nan_a) begin
      sum = a | QBIT64;
    end else if (nan_b) begin
      sum = b | QBIT64;
    end else if (inf_a && inf_b) begin
      sum = (a == b) ? a : DNAN64;
    end else if (inf_a) begin
      sum = a;
    end else if (inf_b) begin
      sum = b;
    end else if ((acc == '0) && !lost) begin
      // exact zero: sign follows the direction rule for zero sums
      if (mode == RM_DOWN) sum = ((a == '0) && (b == '0)) ? '0 : SGN64;
      else                 sum = ((a == SGN64) && (b == SGN64)) ? SGN64 : '0;
    end else if (exp_n >= 12'd2047) begin
      sum = {sgn, away ? INF64[62:0] : MAXF64[62:0]};
    end else begin
      sum = {sgn, rnd};
    end
  end

endmodule

`default_nettype wire

>>> hdl/rounding_ambiguity_check.sv
// ----------------------------------------------------------------------------
// rounding_ambiguity_check
// Decides whether a double result with an error term rounds unambiguously.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one word per check: z_bits (computed result), err_bits
//   (its error correction) and round_mode. rsp returns z_out and the
//   ambiguous flag, one result word for each request word, in order.
//   In nearest mode z_out is z stepped one unit toward er when the error
//   passes half an ulp; in the directed modes z_out is z + er rounded in
//   that direction. ambiguous uses the high words and the low word of z.
// Timing:
//   A word taken into the input register passes to the result register,
//   which presents it on rsp. The two registers enclose the check and
//   the directed adder; a new word is taken every cycle while rsp is ready.
// Reset:
//   rst (synchronous) empties both registers; rsp.valid drops low.
// Backpressure:
//   When rsp stalls, the result register holds and the input register
//   still takes one more word; req.ready then drops until rsp drains.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rounding_ambiguity_check import rac_pkg::*; (
  input wire     clk,
  input wire     rst,
  rac_in_if.sink   req,
  rac_out_if.source rsp
);

  // input stage
  logic   s1_valid;
  dbl_t   s1_z, s1_e;
  rmode_t s1_mode;

  // result stage
  logic   o_valid;
  dbl_t   o_z;
  logic   o_amb;

  logic   out_load, s1_move, take;

  // datapath
  word_t  hz, hr, ie, iz, iz_adj, kn, kd, jn, jd, dd;
  logic   diff_sign, mant_zero;
  dbl_t   dir_sum;
  dbl_t   z_next;
  logic   amb_next;

  rac_dir_add u_add (
    .a    (s1_z),
    .b    (s1_e),
    .mode (s1_mode),
    .sum  (dir_sum)
  );

  assign out_load  = !o_valid || rsp.ready;
  assign s1_move   = s1_valid && out_load;
  assign req.ready = !s1_valid || out_load;
  assign take      = req.valid && req.ready;

  always_comb begin
    hz        = s1_z[63:32];
    hr        = s1_e[63:32];
    ie        = hr & MAG_MASK;
    iz        = hz & EXP_MASK;
    diff_sign = hz[31] ^ hr[31];
    mant_zero = (s1_z[31:0] | (hz & HMAN_MASK)) == '0;
    // a power of two with an opposite error sits one binade lower
    iz_adj    = iz - ((s1_mode == RM_NEAREST) ? NEAR_BIAS : DIR_BIAS)
                   - ((mant_zero && diff_sign) ? ONE_EXP : '0);
    jn        = 32'd4 + ((ie & PROBE_BIT) >> 6);
    jd        = 32'd2 + ((ie & PROBE_BIT) >> 7);
    kn        = (ie + jn) & NEAR_TRUNC;
    kd        = (ie + jd) & DIR_TRUNC;
    dd        = iz_adj - ie;
    z_next    = s1_z;
    amb_next  = 1'b0;
    if (s1_mode == RM_NEAREST) begin
      if (kn == iz_adj) begin
        amb_next = 1'b1;
      end else if ($signed(kn) > $signed(iz_adj)) begin
        // error passes half an ulp: step one unit toward er
        z_next = diff_sign ? s1_z - 64'd1 : s1_z + 64'd1;
      end
    end else begin
      z_next   = dir_sum;
      amb_next = (kd == iz_adj) || (kd == iz_adj + ONE_EXP) ||
                 ($signed(dd) >= $signed(FAR_LIMIT));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_z    <= req.z_bits;
      s1_e    <= req.err_bits;
      s1_mode <= req.round_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_load) begin
      o_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      o_z   <= z_next;
      o_amb <= amb_next;
    end
  end

  assign rsp.valid     = o_valid;
  assign rsp.z_out     = o_z;
  assign rsp.ambiguous = o_amb;

  `ASSERT_NEXT(a_advance, clk, rst, s1_valid && out_load, rsp.valid)
  `ASSERT_IMPL(a_empty_ready, clk, rst, !s1_valid, req.ready)
  `ASSERT_IMPL(a_full_stall, clk, rst, s1_valid && rsp.valid && !rsp.ready, !req.ready)

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for rounding_ambiguity_check: expected words are worked out by a
// predictor of the check and the directed adder, and each result word is
// compared in order against them while both channels idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import rac_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    dbl_t z_out;
    logic ambiguous;
  } check_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rac_in_if  req_ch ();
  rac_out_if rsp_ch ();

  rounding_ambiguity_check dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  check_word_t pending_results[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hold every input at a known value from time zero.
  initial begin
    req_ch.valid      = 1'b0;
    req_ch.z_bits     = '0;
    req_ch.err_bits   = '0;
    req_ch.round_mode = RM_NEAREST;
    rsp_ch.ready      = 1'b0;
  end

  // Bail out if the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver stalls: rotate through always-ready, light, heavy and periodic stall
  // styles so back pressure lands on every phase of the two-stage pipe.
  always @(posedge clk) begin
    case ((cycle_count / 150) % 4)
      0: begin
        rsp_ch.ready <= 1'b1;
      end
      1: begin
        rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      end
      2: begin
        rsp_ch.ready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        rsp_ch.ready <= cycle_count[2];
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic is_nan64(dbl_t b);
    return (b[62:52] == 11'h7ff) && (b[51:0] != '0);
  endfunction

  function automatic logic is_inf64(dbl_t b);
    return (b & ~SGN64) == INF64;
  endfunction

  // z + er rounded in the directed mode. The host adds to nearest; the
  // two-sum error term tells which way the exact sum lies from that.
  function automatic dbl_t directed_sum(dbl_t zb, dbl_t eb, rmode_t mode);
    real  a, b, s, bb, e;
    dbl_t sb;
    logic s_pos, e_pos, away;
    if (is_nan64(zb)) return zb | QBIT64;
    if (is_nan64(eb)) return eb | QBIT64;
    if (is_inf64(zb) && is_inf64(eb)) return (zb == eb) ? zb : DNAN64;
    if (is_inf64(zb)) return zb;
    if (is_inf64(eb)) return eb;
    a = $bitstoreal(zb);
    b = $bitstoreal(eb);
    s = a + b;
    sb = $realtobits(s);
    s_pos = ~sb[63];
    if (is_inf64(sb)) begin
      // overflow: keep the infinity only when rounding away on that side
      away = (mode == RM_UP && s_pos) || (mode == RM_DOWN && !s_pos);
      return away ? sb : sb - 64'd1;
    end
    if (s == 0.0) begin
      if (mode == RM_DOWN && !(zb == '0 && eb == '0)) return SGN64;
      return sb;
    end
    bb = s - a;
    e = (a - (s - bb)) + (b - bb);
    if (e == 0.0) return sb;
    e_pos = e > 0.0;
    case (mode)
      RM_ZERO: begin
        if (e_pos != s_pos) sb = sb - 64'd1;
      end
      RM_UP: begin
        if (e_pos) sb = s_pos ? sb + 64'd1 : sb - 64'd1;
      end
      default: begin
        if (!e_pos) sb = s_pos ? sb - 64'd1 : sb + 64'd1;
      end
    endcase
    return sb;
  endfunction

  function automatic check_word_t predict_check(dbl_t zb, dbl_t eb, rmode_t mode);
    check_word_t r;
    word_t hz, hr, ie, iz, j, k;
    logic diff_sign, mant_zero;
    logic signed [31:0] exp_gap;
    hz = zb[63:32];
    hr = eb[63:32];
    ie = hr & MAG_MASK;
    iz = hz & EXP_MASK;
    diff_sign = hz[31] ^ hr[31];
    mant_zero = (zb[31:0] | (hz & HMAN_MASK)) == '0;
    r.z_out = zb;
    r.ambiguous = 1'b0;
    if (mode == RM_NEAREST) begin
      iz = iz - NEAR_BIAS;
      if (mant_zero && diff_sign) iz = iz - ONE_EXP;
      j = 32'd4 + ((ie & PROBE_BIT) >> 6);
      k = (ie + j) & NEAR_TRUNC;
      if (k == iz)
        r.ambiguous = 1'b1;
      else if ($signed(k) > $signed(iz))
        r.z_out = diff_sign ? zb - 64'd1 : zb + 64'd1;
    end else begin
      r.z_out = directed_sum(zb, eb, mode);
      iz = iz - DIR_BIAS;
      if (mant_zero && diff_sign) iz = iz - ONE_EXP;
      j = 32'd2 + ((ie & PROBE_BIT) >> 7);
      k = (ie + j) & DIR_TRUNC;
      exp_gap = $signed(iz - ie) >>> 20;
      if (k == iz || k == iz + ONE_EXP || exp_gap >= 19) r.ambiguous = 1'b1;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    check_word_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: z_out=%h", rsp_ch.z_out);
        mismatches = mismatches + 1;
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.z_out !== want.z_out) begin
          $error("z_out expected %h actual %h", want.z_out, rsp_ch.z_out);
          mismatches = mismatches + 1;
        end
        if (rsp_ch.ambiguous !== want.ambiguous) begin
          $error("ambiguous expected %0b actual %0b", want.ambiguous, rsp_ch.ambiguous);
          mismatches = mismatches + 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  // Present one word and hold it until taken; valid stays high afterwards
  // so back-to-back words need no gap.
  task automatic send_word(dbl_t zb, dbl_t eb, rmode_t mode);
    req_ch.valid      <= 1'b1;
    req_ch.z_bits     <= zb;
    req_ch.err_bits   <= eb;
    req_ch.round_mode <= mode;
    do @(posedge clk); while (!req_ch.ready);
    pending_results.push_back(predict_check(zb, eb, mode));
  endtask

  task automatic idle_sender(int unsigned n);
    req_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic dbl_t rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Error term whose high word lands near the ambiguity window of z for the
  // given bias, so both the flag and the nearest step get exercised.
  function automatic dbl_t near_window_err(dbl_t zb, word_t bias);
    word_t target, hi;
    target = (zb[63:32] & EXP_MASK) - bias;
    hi = (target + $urandom_range(0, 24) - 12) & MAG_MASK;
    hi[31] = 1'($urandom_range(0, 1));
    return {hi, $urandom()};
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_special_operands();
    dbl_t pinf, ninf, pmax, nz, sub, one;
    pinf = INF64;
    ninf = INF64 | SGN64;
    pmax = MAXF64;
    nz   = SGN64;
    sub  = 64'h0000_0000_0000_0001;
    one  = 64'h3ff0_0000_0000_0000;
    for (int m = 0; m < 4; m++) begin
      send_word(64'd0, 64'd0, rmode_t'(m));            // +0 + +0
      send_word(nz, nz, rmode_t'(m));                  // -0 + -0
      send_word(one, one | SGN64, rmode_t'(m));        // exact cancel
      send_word(pmax, 64'h7ca0_0000_0000_0000, rmode_t'(m)); // overflow
    end
    send_word(pinf, ninf, RM_UP);
    send_word(pinf, pinf, RM_DOWN);
    send_word(one, ninf, RM_ZERO);
    send_word(64'h7ff0_0000_0000_0001, one, RM_UP);    // signaling NaN z
    send_word(one, 64'hfff0_0000_dead_0000, RM_DOWN);  // NaN er
    send_word(sub, sub | SGN64, RM_ZERO);
    send_word(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, RM_NEAREST);
    send_word(one, 64'h3ca0_0000_0000_0000, RM_NEAREST); // half ulp
    send_word(one, 64'h3cb0_0000_0000_0000, RM_ZERO);    // near one ulp
    idle_sender(1);
  endtask

  task automatic test_random(int unsigned count);
    int unsigned burst;
    dbl_t zb, eb;
    rmode_t mode;
    burst = 0;
    for (int unsigned i = 0; i < count; i++) begin
      if (burst == 0) begin
        // gap between bursts, sometimes none at all
        if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 6));
        burst = $urandom_range(1, 40);
      end
      burst--;
      mode = rmode_t'($urandom_range(0, 3));
      zb = rand64();
      case ($urandom_range(0, 9))
        0, 1: begin
          eb = rand64();
        end
        2: begin
          zb[62:52] = $urandom_range(0, 1) ? 11'h7ff : 11'h000;
          eb = $urandom_range(0, 1) ? rand64() : near_window_err(zb, DIR_BIAS);
        end
        3: begin
          // mantissa of z all zero, er of opposite sign
          zb[51:0] = '0;
          eb = near_window_err(zb, (mode == RM_NEAREST) ? NEAR_BIAS : DIR_BIAS);
          eb[63] = ~zb[63];
        end
        default: begin
          zb[62:52] = 11'($urandom_range(60, 2000));
          eb = near_window_err(zb, (mode == RM_NEAREST) ? NEAR_BIAS : DIR_BIAS);
        end
      endcase
      send_word(zb, eb, mode);
    end
    idle_sender(1);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_special_operands();
    test_random(1850);
    // drain, then allow the pipe latency to flush any stray word
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
